// ===== rtl/wfd_pkg.sv =====
package wfd_pkg;

    localparam int MAX_FRAME_BUFFER = 4096;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'(MAX_FRAME_BUFFER - 8);

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [2:0] KEY_BYTES = 3'd4;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW = $clog2(Q_DEPTH);
    localparam int Q_CW = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_LONG  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       last;
        kind_t      kind;
    } q_entry_t;

endpackage

// ===== rtl/websocket_frame_decoder_top.sv =====
// Channel   Dir  tdata                  tlast       tuser
// s_axis    in   [7:0] data_byte        -           -
// m_axis    out  [7:0] payload_byte     frame_end   [1:0] kind
// cfg       in   [15:0] max_payload (write on cfg_we)
//
// One byte is accepted per cycle unless the queue is full; parser state is registered.
// A result is first written into the queue, then loaded into the output register.
// A four-entry queue sits between parser and output; s_tready drops only when it is full.
// Reset (rst_n, async): parser waits for a first header byte, max_payload is 4088.
module websocket_frame_decoder_top
    import wfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] payload_byte
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic     push;
    q_entry_t push_entry;
    logic     q_full;
    logic     q_empty;
    logic     pop;
    q_entry_t pop_entry;

    wfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    wfd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .pop_entry  (pop_entry)
    );

    wfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_entry  (pop_entry),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/wfd_front.sv =====
module wfd_front
    import wfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        q_full,
    output logic        push,
    output q_entry_t    push_entry
);

    typedef enum logic [5:0] {
        PH_HDR0 = 6'b000001,
        PH_HDR1 = 6'b000010,
        PH_EXT  = 6'b000100,
        PH_KEY  = 6'b001000,
        PH_DATA = 6'b010000,
        PH_DROP = 6'b100000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        masked_reg, masked_next;
    logic [3:0]  ext_left_reg, ext_left_next;
    logic [2:0]  key_left_reg, key_left_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  key_index_reg, key_index_next;
    logic [15:0] max_payload_reg;

    logic        accept;
    logic [63:0] hd_len;
    logic        run_after;
    logic        run_done;
    logic [7:0]  kb;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    always_comb
    begin
        case (key_index_reg)
            2'd0:    kb = key_reg[31:24];
            2'd1:    kb = key_reg[23:16];
            2'd2:    kb = key_reg[15:8];
            default: kb = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        masked_next    = masked_reg;
        ext_left_next  = ext_left_reg;
        key_left_next  = key_left_reg;
        len_next       = len_reg;
        key_next       = key_reg;
        key_index_next = key_index_reg;
        hd_len         = len_reg;
        run_after      = 1'b0;
        run_done       = 1'b0;
        push           = 1'b0;
        push_entry     = '{data: 8'd0, key: 8'd0, last: 1'b1, kind: KIND_EMPTY};

        if (accept)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    masked_next = s_tdata[7];
                    if (s_tdata[6:0] == LEN_CODE_16)
                    begin
                        ext_left_next = EXT_BYTES_16;
                        len_next      = 64'd0;
                        phase_next    = PH_EXT;
                    end
                    else if (s_tdata[6:0] == LEN_CODE_64)
                    begin
                        ext_left_next = EXT_BYTES_64;
                        len_next      = 64'd0;
                        phase_next    = PH_EXT;
                    end
                    else
                    begin
                        hd_len    = {57'd0, s_tdata[6:0]};
                        run_after = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    hd_len        = {len_reg[55:0], s_tdata};
                    len_next      = hd_len;
                    ext_left_next = ext_left_reg - 4'd1;
                    if (ext_left_reg == 4'd1)
                    begin
                        run_after = 1'b1;
                    end
                end
                PH_KEY:
                begin
                    key_next      = {key_reg[23:0], s_tdata};
                    key_left_next = key_left_reg - 3'd1;
                    if (key_left_reg == 3'd1)
                    begin
                        run_done = 1'b1;
                    end
                end
                PH_DATA:
                begin
                    key_index_next = key_index_reg + 2'd1;
                    len_next       = len_reg - 64'd1;
                    push           = 1'b1;
                    push_entry     = '{data: s_tdata,
                                       key:  masked_reg ? kb : 8'd0,
                                       last: len_reg == 64'd1,
                                       kind: KIND_DATA};
                    if (len_reg == 64'd1)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                PH_DROP:
                begin
                    len_next = len_reg - 64'd1;
                    if (len_reg == 64'd1)
                    begin
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR1;
                end
            endcase

            if (run_after)
            begin
                if (masked_next)
                begin
                    len_next      = hd_len;
                    key_next      = 32'd0;
                    key_left_next = KEY_BYTES;
                    phase_next    = PH_KEY;
                end
                else
                begin
                    run_done = 1'b1;
                end
            end

            if (run_done)
            begin
                key_index_next = 2'd0;
                len_next       = hd_len;
                if (hd_len == 64'd0)
                begin
                    phase_next = PH_HDR0;
                    push       = 1'b1;
                    push_entry = '{data: 8'd0, key: 8'd0, last: 1'b1, kind: KIND_EMPTY};
                end
                else if (hd_len > {48'd0, max_payload_reg})
                begin
                    phase_next = PH_DROP;
                    push       = 1'b1;
                    push_entry = '{data: 8'd0, key: 8'd0, last: 1'b1, kind: KIND_LONG};
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HDR0;
            masked_reg      <= 1'b0;
            ext_left_reg    <= 4'd0;
            key_left_reg    <= 3'd0;
            len_reg         <= 64'd0;
            key_reg         <= 32'd0;
            key_index_reg   <= 2'd0;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else
        begin
            phase_reg     <= phase_next;
            masked_reg    <= masked_next;
            ext_left_reg  <= ext_left_next;
            key_left_reg  <= key_left_next;
            len_reg       <= len_next;
            key_reg       <= key_next;
            key_index_reg <= key_index_next;
            if (cfg_we)
            begin
                max_payload_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ===== rtl/wfd_queue.sv =====
module wfd_queue
    import wfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output q_entry_t pop_entry
);

    q_entry_t          mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_CW-1:0]   count_reg;

    assign full      = count_reg == Q_CW'(Q_DEPTH);
    assign empty     = count_reg == '0;
    assign pop_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + Q_CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - Q_CW'(1);
            end
        end
    end

endmodule

// ===== rtl/wfd_back.sv =====
module wfd_back
    import wfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  q_entry_t   q_entry,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [1:0] m_tuser
);

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    kind_t      m_kind_reg;

    assign pop      = !q_empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (pop)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // unmask while loading the output register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_tdata_reg <= q_entry.data ^ q_entry.key;
            m_tlast_reg <= q_entry.last;
            m_kind_reg  <= q_entry.kind;
        end
    end

endmodule

// ===== rtl/wfd_checker.sv =====
module wfd_checker
    import wfd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output transaction changed while stalled");

    a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_EMPTY || m_tuser == KIND_LONG)
            |-> m_tlast && m_tdata == 8'd0)
        else $error("status result without frame end or with data");

    a_full_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled while output is empty");

endmodule

bind websocket_frame_decoder_top wfd_checker u_wfd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== verif/wfd_frame_check.sv =====
`timescale 1ns / 1ps

module wfd_frame_check
    import wfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] payload_byte
    input  logic        m_tlast,
    input  logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          mismatches,
    output int          outstanding
);

    typedef enum logic [2:0] {
        ST_HDR0,
        ST_HDR1,
        ST_EXT,
        ST_KEY,
        ST_DATA,
        ST_DROP
    } parse_st_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        kind_t      kind;
    } frame_result_t;

    parse_st_t     st;
    logic          is_masked;
    logic [3:0]    ext_left;
    logic [2:0]    key_left;
    logic [63:0]   frame_len;
    logic [31:0]   mask_key;
    logic [1:0]    key_idx;
    logic [63:0]   remaining;
    logic [15:0]   max_len;
    frame_result_t pending_results[$];
    int            fail_count = 0;

    initial
    begin
        mismatches = 0;
        outstanding = 0;
    end

    task automatic finish_header(output bit got, output frame_result_t res);
        got = 1'b0;
        res = '0;
        key_idx = 2'd0;
        remaining = frame_len;
        if (frame_len == 64'd0)
        begin
            st = ST_HDR0;
            got = 1'b1;
            res.last = 1'b1;
            res.kind = KIND_EMPTY;
        end
        else if (frame_len > 64'(max_len))
        begin
            st = ST_DROP;
            got = 1'b1;
            res.last = 1'b1;
            res.kind = KIND_LONG;
        end
        else
        begin
            st = ST_DATA;
        end
    endtask

    task automatic finish_length(output bit got, output frame_result_t res);
        got = 1'b0;
        res = '0;
        if (is_masked)
        begin
            mask_key = 32'd0;
            key_left = KEY_BYTES;
            st = ST_KEY;
        end
        else
        begin
            finish_header(got, res);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, output bit got, output frame_result_t res);
        logic [7:0] kb;
        got = 1'b0;
        res = '0;
        kb = 8'h00;
        case (st)
            ST_HDR1:
            begin
                is_masked = b[7];
                frame_len = 64'd0;
                if (b[6:0] == LEN_CODE_16)
                begin
                    ext_left = EXT_BYTES_16;
                    st = ST_EXT;
                end
                else if (b[6:0] == LEN_CODE_64)
                begin
                    ext_left = EXT_BYTES_64;
                    st = ST_EXT;
                end
                else
                begin
                    frame_len = 64'(b[6:0]);
                    finish_length(got, res);
                end
            end
            ST_EXT:
            begin
                frame_len = {frame_len[55:0], b};
                ext_left = ext_left - 4'd1;
                if (ext_left == 4'd0)
                    finish_length(got, res);
            end
            ST_KEY:
            begin
                mask_key = {mask_key[23:0], b};
                key_left = key_left - 3'd1;
                if (key_left == 3'd0)
                    finish_header(got, res);
            end
            ST_DATA:
            begin
                if (is_masked)
                    kb = mask_key[31 - 8 * key_idx -: 8];
                key_idx = key_idx + 2'd1;
                remaining = remaining - 64'd1;
                got = 1'b1;
                res.data = b ^ kb;
                res.kind = KIND_DATA;
                res.last = (remaining == 64'd0);
                if (remaining == 64'd0)
                    st = ST_HDR0;
            end
            ST_DROP:
            begin
                remaining = remaining - 64'd1;
                if (remaining == 64'd0)
                    st = ST_HDR0;
            end
            default:
            begin
                st = ST_HDR1;
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input frame_result_t want);
        if (fail_count < 10)
            $display("%s: expected data %02h last %0d kind %0d, got data %02h last %0d kind %0d",
                     what, want.data, want.last, want.kind, m_tdata, m_tlast, m_tuser);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        frame_result_t res;
        frame_result_t want;
        bit            got;
        if (!rst_n)
        begin
            st = ST_HDR0;
            is_masked = 1'b0;
            ext_left = 4'd0;
            key_left = 3'd0;
            frame_len = 64'd0;
            mask_key = 32'd0;
            key_idx = 2'd0;
            remaining = 64'd0;
            max_len = MAX_PAYLOAD_RESET;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                max_len = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, got, res);
                if (got)
                    pending_results.push_back(res);
            end
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    want = '0;
                    note_mismatch("unexpected transaction", want);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.last
                        || m_tuser !== want.kind)
                        note_mismatch("mismatch", want);
                end
            end
            outstanding <= pending_results.size();
            mismatches <= fail_count;
        end
    end

endmodule

// ===== verif/tb_websocket_frame_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_websocket_frame_decoder_top;
    import wfd_pkg::*;

    localparam int ENC_SHORT = 0;
    localparam int ENC_16 = 1;
    localparam int ENC_64 = 2;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_BYTES = 40;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    int          mismatches;
    int          outstanding;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          sent_bytes = 0;
    int          cur_max = MAX_PAYLOAD_RESET;
    logic        hold_req = 1'b0;
    logic        hold_taken;
    int          hold_left;
    int          quiet_cycles = 0;

    websocket_frame_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    wfd_frame_check u_frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hold off the receiver once for a long stretch, otherwise stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sent_bytes++;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_max_payload(input logic [15:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_max = value;
    endtask

    task automatic send_frame(input logic msk, input int enc, input logic [63:0] len64,
                              input int nbytes);
        logic [31:0] key;
        key = $urandom();
        send_byte(8'($urandom_range(0, 255)));
        case (enc)
            ENC_16:
            begin
                send_byte({msk, LEN_CODE_16});
                send_byte(len64[15:8]);
                send_byte(len64[7:0]);
            end
            ENC_64:
            begin
                send_byte({msk, LEN_CODE_64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len64[8 * i +: 8]);
            end
            default:
            begin
                send_byte({msk, len64[6:0]});
            end
        endcase
        if (msk)
            for (int i = 3; i >= 0; i--)
                send_byte(key[8 * i +: 8]);
        repeat (nbytes) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_frame();
        int len;
        int enc;
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            len = 0;
        else if (r < 65)
            len = $urandom_range(1, 30);
        else if (r < 78 && cur_max < 400)
            len = cur_max + $urandom_range(0, 1);
        else if (r < 90)
            len = $urandom_range(31, 300);
        else
            len = $urandom_range(1, 125);
        r = $urandom_range(0, 9);
        if (len > 125)
            enc = (r < 3) ? ENC_64 : ENC_16;
        else
            enc = (r < 7) ? ENC_SHORT : ((r < 9) ? ENC_16 : ENC_64);
        send_frame(1'($urandom_range(0, 1)), enc, 64'(len), len);
    endtask

    initial
    begin : stimulus
        int          target;
        logic [15:0] max_by_phase[4];
        logic [63:0] huge_len;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(1'b1, ENC_SHORT, 64'd3, 3);
        send_frame(1'b0, ENC_SHORT, 64'd0, 0);
        send_frame(1'b1, ENC_SHORT, 64'd0, 0);

        set_max_payload(16'd20);
        send_frame(1'b0, ENC_SHORT, 64'd20, 20);
        send_frame(1'b1, ENC_SHORT, 64'd21, 21);
        send_frame(1'b0, ENC_16, 64'd0, 0);
        send_frame(1'b1, ENC_64, 64'd0, 0);
        send_frame(1'b1, ENC_16, 64'd5, 5);
        send_frame(1'b0, ENC_64, 64'd7, 7);
        send_frame(1'b0, ENC_SHORT, 64'd125, 125);
        send_frame(1'b1, ENC_16, 64'd300, 300);

        set_max_payload(16'd0);
        send_frame(1'b0, ENC_SHORT, 64'd1, 1);
        send_frame(1'b1, ENC_SHORT, 64'd0, 0);

        max_by_phase[0] = 16'hffff;
        max_by_phase[1] = 16'd0;
        max_by_phase[2] = 16'd40;
        max_by_phase[3] = 16'($urandom_range(0, 65535));

        for (int p = 0; p < 4; p++)
        begin
            set_max_payload(max_by_phase[p]);
            case (p)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                    hold_req = 1'b1;
                end
                1:
                begin
                    idle_pct = 75;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 75;
                end
                default:
                begin
                    idle_pct = 38;
                    stall_pct = 38;
                end
            endcase
            target = sent_bytes + PHASE_BYTES;
            while (sent_bytes < target)
                send_random_frame();
        end

        // length with its top bit set: always too long, payload never ends
        huge_len = {$urandom(), $urandom()} | 64'h8000_0000_0000_0000;
        send_frame(1'b1, ENC_64, huge_len, 6);
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
